// ----- src/ppd_pkg.sv -----
// Shared types and constants for the pairwise point distance block.
package ppd_pkg;

	// Request operation codes
	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_PAIRS = 1'b1
	} op_t;

	// Response status codes
	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

	// Pair sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_I,
		ST_LOAD_J,
		ST_MUL,
		ST_SQRT,
		ST_EMIT
	} state_t;

	// Fixed response field widths
	localparam int unsigned IDX_OUT_W = 3;
	localparam int unsigned DIST_W    = 17;

endpackage

// ----- src/pairwise_point_distance.sv -----
// Point store with a bit-serial squared-distance and square-root sequencer.
//
// Usage: the request channel (req_valid / req_stall) carries op, x_coord and
// y_coord. An add request (op 0) appends a point and answers with a single
// response: status 0, or status 1 when the store already holds MAX_POINTS and
// the point is dropped. A pairs request (op 1) answers with one response per
// stored pair (i, j), i < j, in i-major order, last set on the final pair; with
// fewer than two points stored it answers nothing. The store is kept.
// Each distance is floor(sqrt(dx^2 + dy^2)) with FRAC_BITS fraction bits.
// An add response appears the cycle after acceptance. Each pair steps through
// operand fetch, the multiply (one multiplier bit per cycle), the square root
// (one root bit per cycle) and hand over; the first point of each row is
// fetched once per row, before the first pair of that row.
// One request is worked on at a time; req_stall is high until it is done.
// Reset empties the store (the point count returns to zero) and drops any
// pending response. While rsp_stall is high the response holds and the
// sequencer waits before handing over the next one.
module pairwise_point_distance #(
	parameter int unsigned MAX_POINTS = 8,
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned FRAC_BITS  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             op,
	input  logic signed [COORD_BITS-1:0]     x_coord,
	input  logic signed [COORD_BITS-1:0]     y_coord,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             status,
	output logic [ppd_pkg::IDX_OUT_W-1:0]    first_index,
	output logic [ppd_pkg::IDX_OUT_W-1:0]    second_index,
	output logic [ppd_pkg::DIST_W-1:0]       distance,
	output logic                             last
);
	import ppd_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
	localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;
	localparam int unsigned ROOT_W = COORD_BITS + FRAC_BITS + 1;
	localparam int unsigned RAD_W  = 2 * ROOT_W;
	localparam int unsigned REM_W  = ROOT_W + 2;
	localparam int unsigned STEP_W = $clog2(ROOT_W + 1);
	localparam int unsigned DW     = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

	// Point store
	logic signed [COORD_BITS-1:0] sx_q [MAX_POINTS];
	logic signed [COORD_BITS-1:0] sy_q [MAX_POINTS];
	logic [CNT_W-1:0]             count_q;

	// Sequencer
	state_t           state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q;
	logic [STEP_W-1:0] step_q;
	logic signed [COORD_BITS-1:0] xi_q, yi_q;

	// Bit-serial multiplier
	logic [SQ_W-1:0]       acc_q, mcx_q, mcy_q;
	logic [COORD_BITS-1:0] mx_q, my_q;

	// Digit-by-digit square root
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	// Response register
	logic                 rsp_valid_q;
	logic                 status_q;
	logic [IDX_OUT_W-1:0] first_q, second_q;
	logic [DIST_W-1:0]    dist_q;
	logic                 last_q;

	logic req_acc, out_free, load_out, pair_last, row_end, step_done;
	logic [IDX_W-1:0] rd_addr;
	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	logic signed [COORD_BITS:0]   diff_x, diff_y;
	logic [COORD_BITS-1:0]        dx, dy;
	logic [REM_W-1:0]  rem_sh, trial;
	logic [DW-1:0]     root_ext;
	logic [IDX_W:0]    i_next2;

	// Store read port, shared by the row and column fetch
	assign rd_addr = (state_q == ST_LOAD_I) ? i_q : j_q;
	assign rd_x    = sx_q[rd_addr];
	assign rd_y    = sy_q[rd_addr];

	// Absolute coordinate differences
	assign diff_x = {xi_q[COORD_BITS-1], xi_q} - {rd_x[COORD_BITS-1], rd_x};
	assign diff_y = {yi_q[COORD_BITS-1], yi_q} - {rd_y[COORD_BITS-1], rd_y};
	assign dx     = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
	assign dy     = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

	// Root step operands
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	// Pair position
	assign row_end   = (CNT_W'(j_q) == count_q - CNT_W'(1));
	assign pair_last = row_end && (CNT_W'(i_q) == count_q - CNT_W'(2));
	assign i_next2   = {1'b0, i_q} + (IDX_W + 1)'(2);

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_acc  = req_valid && !req_stall;

	// Step counter end for the multiply and root phases
	always_comb begin
		step_done = 1'b0;
		if (state_q == ST_MUL) begin
			step_done = (step_q == STEP_W'(COORD_BITS - 1));
		end else if (state_q == ST_SQRT) begin
			step_done = (step_q == STEP_W'(ROOT_W - 1));
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = !out_free;
				if (req_valid && out_free) begin
					if (op == OP_ADD) begin
						load_out = 1'b1;
					end else if (count_q >= CNT_W'(2)) begin
						state_d = ST_LOAD_I;
					end
				end
			end
			ST_LOAD_I: state_d = ST_LOAD_J;
			ST_LOAD_J: state_d = ST_MUL;
			ST_MUL: begin
				if (step_done) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (step_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					priority if (pair_last) begin
						state_d = ST_IDLE;
					end else if (row_end) begin
						state_d = ST_LOAD_I;
					end else begin
						state_d = ST_LOAD_J;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req_acc && op == OP_ADD && count_q < CNT_W'(MAX_POINTS)) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Append a point below the count
	always_ff @(posedge clk) begin
		if (req_acc && op == OP_ADD && count_q < CNT_W'(MAX_POINTS)) begin
			sx_q[count_q[IDX_W-1:0]] <= x_coord;
			sy_q[count_q[IDX_W-1:0]] <= y_coord;
		end
	end

	// Pair indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (req_acc) begin
			i_q <= '0;
			j_q <= IDX_W'(1);
		end else if (state_q == ST_EMIT && out_free && !pair_last) begin
			if (row_end) begin
				i_q <= i_q + IDX_W'(1);
				j_q <= i_next2[IDX_W-1:0];
			end else begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_MUL || state_q == ST_SQRT) begin
			step_q <= step_done ? '0 : step_q + STEP_W'(1);
		end else begin
			step_q <= '0;
		end
	end

	// Fetch operands, multiply one bit per cycle, extract one root bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD_I: begin
				xi_q <= rd_x;
				yi_q <= rd_y;
			end
			ST_LOAD_J: begin
				acc_q <= '0;
				mcx_q <= SQ_W'(dx);
				mcy_q <= SQ_W'(dy);
				mx_q  <= dx;
				my_q  <= dy;
			end
			ST_MUL: begin
				acc_q <= acc_q + (mx_q[0] ? mcx_q : '0) + (my_q[0] ? mcy_q : '0);
				mcx_q <= mcx_q << 1;
				mcy_q <= mcy_q << 1;
				mx_q  <= mx_q >> 1;
				my_q  <= my_q >> 1;
				if (step_done) begin
					rad_q  <= RAD_W'(acc_q + (mx_q[0] ? mcx_q : '0) + (my_q[0] ? mcy_q : '0))
						<< (2 * FRAC_BITS);
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign root_ext = DW'(root_q);

	// Response valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_IDLE) begin
				status_q <= (count_q < CNT_W'(MAX_POINTS)) ? STATUS_OK : STATUS_FULL;
				first_q  <= '0;
				second_q <= '0;
				dist_q   <= '0;
				last_q   <= 1'b1;
			end else begin
				status_q <= STATUS_OK;
				first_q  <= IDX_OUT_W'(i_q);
				second_q <= IDX_OUT_W'(j_q);
				dist_q   <= root_ext[DIST_W-1:0];
				last_q   <= pair_last;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign first_index  = first_q;
	assign second_index = second_q;
	assign distance     = dist_q;
	assign last         = last_q;

endmodule
